>>> sv/efla_pkg.sv
package efla_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_BITS     = 48;
    localparam int FIELD_W       = 48;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam logic CMD_FREE  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_ZERO  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic               command;
        logic [FIELD_W-1:0] extent_pos;
        logic [FIELD_W-1:0] extent_len;
    } t_cmd_in;

    typedef struct packed {
        logic [FIELD_W-1:0] alloc_pos;
        t_status            status;
    } t_result;

    typedef struct packed {
        logic eq;
        logic gt;
        logic le_best;
    } t_fit_flags;

endpackage

>>> sv/efla_fit_cmp.sv
module efla_fit_cmp (
    input  efla_pkg::t_addr      i_len,
    input  efla_pkg::t_addr      i_req,
    input  efla_pkg::t_addr      i_best,
    output efla_pkg::t_fit_flags o_flags
);
    import efla_pkg::*;

    // Shared length comparator used once per table entry during a scan.
    always_comb begin
        o_flags.eq      = (i_len == i_req);
        o_flags.gt      = (i_len > i_req);
        o_flags.le_best = (i_len <= i_best);
    end

endmodule

>>> sv/extent_free_list_allocator.sv
// Channel  | Ports                        | Handshake
// ---------+------------------------------+-------------------------------------
// command  | start, i_cmd, busy           | taken at an edge with start && !busy
// result   | o_valid, o_result            | o_valid high for one cycle, no stall
//
// A free or a zero-length command answers in the cycle after it is taken.
// An allocate scans the table through the single read port, shifts the younger
// entries down one slot and, for a larger extent, stores the remainder as the
// newest entry.
// Reset is synchronous and active low and empties the table at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
module extent_free_list_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  efla_pkg::t_cmd_in i_cmd,
    output logic              busy,
    output logic              o_valid,
    output efla_pkg::t_result o_result
);
    import efla_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_APPEND = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_chk, n_chk;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    t_addr            r_req, n_req;
    logic             r_exact_found, n_exact_found;
    logic [IDX_W-1:0] r_exact_idx, n_exact_idx;
    t_addr            r_exact_pos, n_exact_pos;
    logic             r_best_found, n_best_found;
    logic [IDX_W-1:0] r_best_idx, n_best_idx;
    t_addr            r_best_pos, n_best_pos;
    t_addr            r_best_len, n_best_len;
    logic             r_use_best, n_use_best;
    logic             r_valid, n_valid;
    t_result          r_result, n_result;
    t_addr            r_rd_pos, r_rd_len;

    t_addr mem_pos [TABLE_ENTRIES];
    t_addr mem_len [TABLE_ENTRIES];

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_addr            wr_pos, wr_len;
    logic [IDX_W-1:0] rd_addr;
    t_addr            in_pos, in_len;
    t_fit_flags       fit;

    efla_fit_cmp u_fit_cmp (
        .i_len   (r_rd_len),
        .i_req   (r_req),
        .i_best  (r_best_len),
        .o_flags (fit)
    );

    assign in_pos  = ADDR_BITS'(i_cmd.extent_pos);
    assign in_len  = ADDR_BITS'(i_cmd.extent_len);
    assign rd_addr = r_idx[IDX_W-1:0];
    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_pos[wr_addr] <= wr_pos;
            mem_len[wr_addr] <= wr_len;
        end
        r_rd_pos <= mem_pos[rd_addr];
        r_rd_len <= mem_len[rd_addr];
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_chk         = r_chk;
        n_chk_idx     = r_chk_idx;
        n_req         = r_req;
        n_exact_found = r_exact_found;
        n_exact_idx   = r_exact_idx;
        n_exact_pos   = r_exact_pos;
        n_best_found  = r_best_found;
        n_best_idx    = r_best_idx;
        n_best_pos    = r_best_pos;
        n_best_len    = r_best_len;
        n_use_best    = r_use_best;
        n_valid       = 1'b0;
        n_result      = r_result;
        wr_en         = 1'b0;
        wr_addr       = r_count[IDX_W-1:0];
        wr_pos        = in_pos;
        wr_len        = in_len;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (in_len == '0) begin
                        n_valid  = 1'b1;
                        n_result = '{alloc_pos: '0, status: ST_ZERO};
                    end else if (i_cmd.command == CMD_FREE) begin
                        n_valid = 1'b1;
                        if (r_count == CNT_W'(TABLE_ENTRIES)) begin
                            n_result = '{alloc_pos: '0, status: ST_FULL};
                        end else begin
                            wr_en    = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                            n_result = '{alloc_pos: '0, status: ST_OK};
                        end
                    end else begin
                        n_req         = in_len;
                        n_idx         = '0;
                        n_chk         = 1'b0;
                        n_exact_found = 1'b0;
                        n_best_found  = 1'b0;
                        n_state       = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Entries arrive oldest first, so the last match seen is the newest.
                if (r_chk) begin
                    if (fit.eq) begin
                        n_exact_found = 1'b1;
                        n_exact_idx   = r_chk_idx;
                        n_exact_pos   = r_rd_pos;
                    end
                    if (fit.gt && (!r_best_found || fit.le_best)) begin
                        n_best_found = 1'b1;
                        n_best_idx   = r_chk_idx;
                        n_best_pos   = r_rd_pos;
                        n_best_len   = r_rd_len;
                    end
                end
                if (r_idx < r_count) begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CNT_W'(1);
                end else begin
                    n_chk = 1'b0;
                    if (!r_chk) begin
                        if (r_exact_found) begin
                            n_use_best = 1'b0;
                            n_idx      = CNT_W'(r_exact_idx) + CNT_W'(1);
                            n_state    = S_SHIFT;
                        end else if (r_best_found) begin
                            n_use_best = 1'b1;
                            n_idx      = CNT_W'(r_best_idx) + CNT_W'(1);
                            n_state    = S_SHIFT;
                        end else begin
                            n_valid  = 1'b1;
                            n_result = '{alloc_pos: '0, status: ST_NOFIT};
                            n_state  = S_IDLE;
                        end
                    end
                end
            end

            S_SHIFT: begin
                // Each younger entry is read from the table and written one slot lower in the cycle after.
                if (r_chk) begin
                    wr_en   = 1'b1;
                    wr_addr = r_chk_idx;
                    wr_pos  = r_rd_pos;
                    wr_len  = r_rd_len;
                end
                if (r_idx < r_count) begin
                    n_chk     = 1'b1;
                    n_chk_idx = IDX_W'(r_idx - CNT_W'(1));
                    n_idx     = r_idx + CNT_W'(1);
                end else begin
                    n_chk = 1'b0;
                    if (!r_chk) begin
                        n_count = r_count - CNT_W'(1);
                        if (r_use_best) begin
                            n_state = S_APPEND;
                        end else begin
                            n_valid  = 1'b1;
                            n_result = '{alloc_pos: FIELD_W'(r_exact_pos), status: ST_OK};
                            n_state  = S_IDLE;
                        end
                    end
                end
            end

            S_APPEND: begin
                wr_en    = 1'b1;
                wr_pos   = r_best_pos + r_req;
                wr_len   = r_best_len - r_req;
                n_count  = r_count + CNT_W'(1);
                n_valid  = 1'b1;
                n_result = '{alloc_pos: FIELD_W'(r_best_pos), status: ST_OK};
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
                n_chk   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_chk   <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_chk_idx     <= n_chk_idx;
        r_req         <= n_req;
        r_exact_found <= n_exact_found;
        r_exact_idx   <= n_exact_idx;
        r_exact_pos   <= n_exact_pos;
        r_best_found  <= n_best_found;
        r_best_idx    <= n_best_idx;
        r_best_pos    <= n_best_pos;
        r_best_len    <= n_best_len;
        r_use_best    <= n_use_best;
        r_result      <= n_result;
    end

endmodule

>>> sv/efla_checker.sv
module efla_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input efla_pkg::t_result o_result
);
    import efla_pkg::*;

    // A result is only shown once the block has gone back to idle.
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Every taken transaction either starts a scan or answers right away.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted transaction produced neither busy nor result");

    // The block only becomes busy because a transaction was taken.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    a_pos_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != ST_OK)) |-> (o_result.alloc_pos == '0))
        else $error("nonzero position on a failed transaction");

endmodule

bind extent_free_list_allocator efla_checker u_efla_checker (.*);

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import efla_pkg::*;

    localparam t_addr ADDR_MAX    = '1;
    localparam int    DRAIN_WAIT  = 2 * TABLE_ENTRIES + 20;
    localparam int    NUM_PHASES  = 5;

    typedef struct packed {
        logic    cmd;
        t_addr   pos;
        t_addr   len;
        logic    typed;
        t_status st;
        t_addr   apos;
    } t_dir_row;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    t_cmd_in           i_cmd   = '0;
    logic              busy;
    logic              o_valid;
    t_result           o_result;

    // Free extents as the testbench expects them, oldest first.
    t_addr   free_pos[$];
    t_addr   free_len[$];
    t_result pending_results[$];
    int      n_fail = 0;
    int      n_sent = 0;
    int      n_by_status[4] = '{0, 0, 0, 0};
    int      peak_entries = 0;

    // The expected result is typed in only for rows whose answer is plain.
    t_dir_row directed_rows [21] = '{
        '{CMD_ALLOC, 48'd0,   48'd5,   1'b1, ST_NOFIT, 48'd0},
        '{CMD_FREE,  48'd77,  48'd0,   1'b1, ST_ZERO,  48'd0},
        '{CMD_ALLOC, ADDR_MAX, 48'd0,  1'b1, ST_ZERO,  48'd0},
        '{CMD_FREE,  ADDR_MAX, ADDR_MAX, 1'b1, ST_OK,  48'd0},
        '{CMD_FREE,  48'd0,   48'd1,   1'b1, ST_OK,    48'd0},
        '{CMD_FREE,  48'd100, 48'd10,  1'b1, ST_OK,    48'd0},
        '{CMD_FREE,  48'd200, 48'd10,  1'b1, ST_OK,    48'd0},
        '{CMD_ALLOC, 48'd0,   48'd10,  1'b0, ST_OK,    48'd0},
        '{CMD_ALLOC, ADDR_MAX, 48'd4,  1'b0, ST_OK,    48'd0},
        '{CMD_ALLOC, 48'd0,   48'd6,   1'b0, ST_OK,    48'd0},
        '{CMD_ALLOC, 48'd0,   ADDR_MAX, 1'b0, ST_OK,   48'd0},
        '{CMD_ALLOC, 48'd0,   48'd2,   1'b1, ST_NOFIT, 48'd0},
        '{CMD_FREE,  48'd500, 48'd30,  1'b1, ST_OK,    48'd0},
        '{CMD_FREE,  48'd300, 48'd20,  1'b1, ST_OK,    48'd0},
        '{CMD_FREE,  48'd400, 48'd20,  1'b1, ST_OK,    48'd0},
        '{CMD_ALLOC, 48'd0,   48'd15,  1'b0, ST_OK,    48'd0},
        '{CMD_FREE,  48'hFFFF_FFFF_FFFE, 48'd4, 1'b1, ST_OK, 48'd0},
        '{CMD_ALLOC, 48'd0,   48'd3,   1'b0, ST_OK,    48'd0},
        '{CMD_ALLOC, 48'd0,   48'd1,   1'b0, ST_OK,    48'd0},
        '{CMD_ALLOC, 48'd0,   48'd1,   1'b0, ST_OK,    48'd0},
        '{CMD_ALLOC, 48'd0,   48'd1,   1'b0, ST_OK,    48'd0}
    };

    // Free percentage, item count and idle percentage of each random phase.
    int phase_free_pct [NUM_PHASES] = '{90, 15, 50, 90, 15};
    int phase_items    [NUM_PHASES] = '{110, 90, 90, 110, 80};
    int phase_idle_pct [NUM_PHASES] = '{40, 0, 25, 60, 0};

    extent_free_list_allocator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Applies one command to the expected free list and returns its answer.
    function automatic t_result predict_extent_cmd(input t_cmd_in c);
        t_result r;
        t_addr   len;
        t_addr   best;
        t_addr   base;
        t_addr   rem_pos;
        int      pick;
        bit      found;
        int      i;
        r.alloc_pos = '0;
        r.status    = ST_OK;
        len   = c.extent_len;
        best  = '0;
        pick  = 0;
        found = 1'b0;
        if (len == '0) begin
            r.status = ST_ZERO;
        end else if (c.command == CMD_FREE) begin
            if (free_len.size() >= TABLE_ENTRIES) begin
                r.status = ST_FULL;
            end else begin
                free_pos = {free_pos, c.extent_pos};
                free_len = {free_len, len};
            end
        end else begin
            for (i = free_len.size() - 1; i >= 0 && !found; i--) begin
                if (free_len[i] == len) begin
                    found = 1'b1;
                    pick  = i;
                end
            end
            if (found) begin
                r.alloc_pos = free_pos[pick];
                free_pos.delete(pick);
                free_len.delete(pick);
            end else begin
                // Smallest larger length; the <= keeps the newest of equal ones.
                for (i = 0; i < free_len.size(); i++) begin
                    if (free_len[i] > len && (!found || free_len[i] <= best)) begin
                        found = 1'b1;
                        best  = free_len[i];
                        pick  = i;
                    end
                end
                if (found) begin
                    base = free_pos[pick];
                    r.alloc_pos = base;
                    free_pos.delete(pick);
                    free_len.delete(pick);
                    rem_pos  = base + len;
                    free_pos = {free_pos, rem_pos};
                    free_len = {free_len, t_addr'(best - len)};
                end else begin
                    r.status = ST_NOFIT;
                end
            end
        end
        if (free_len.size() > peak_entries) peak_entries = free_len.size();
        return r;
    endfunction

    function automatic t_cmd_in random_extent_cmd(input int free_pct);
        t_cmd_in c;
        int      sel;
        c.command    = ($urandom_range(99) < free_pct) ? CMD_FREE : CMD_ALLOC;
        c.extent_pos = t_addr'({$urandom, $urandom});
        sel = $urandom_range(99);
        if (sel < 3)
            c.extent_len = '0;
        else if (sel < 9)
            c.extent_len = t_addr'({$urandom, $urandom});
        else if (sel < 11)
            c.extent_len = ADDR_MAX;
        else
            c.extent_len = t_addr'($urandom_range(1, 24));
        return c;
    endfunction

    function automatic int idle_burst(input int idle_pct);
        return ($urandom_range(99) < idle_pct) ? $urandom_range(1, 14) : 0;
    endfunction

    // Holds the command until the block takes it, then records the expected answer.
    task automatic issue_cmd(input t_cmd_in c, input bit typed, input t_result typed_res,
                             input int gap);
        t_result r;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        r = predict_extent_cmd(c);
        if (typed) r = typed_res;
        pending_results = {pending_results, r};
        n_by_status[r.status]++;
        n_sent++;
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: alloc_pos %h status %0d",
                       o_result.alloc_pos, o_result.status);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    n_fail++;
                end
                if (o_result.alloc_pos !== want.alloc_pos) begin
                    $error("alloc_pos: expected %h, got %h",
                           want.alloc_pos, o_result.alloc_pos);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        t_dir_row row;
        t_cmd_in  c;
        int       p;
        int       k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            c.command    = row.cmd;
            c.extent_pos = row.pos;
            c.extent_len = row.len;
            issue_cmd(c, row.typed, '{alloc_pos: row.apos, status: row.st}, idle_burst(30));
        end
        wait_for_results();

        for (p = 0; p < NUM_PHASES; p++) begin
            for (k = 0; k < phase_items[p]; k++) begin
                issue_cmd(random_extent_cmd(phase_free_pct[p]), 1'b0, '0,
                          idle_burst(phase_idle_pct[p]));
            end
            // Let the table settle once with nothing in flight.
            if (p == 1) wait_for_results();
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d commands: %0d ok, %0d no fit, %0d zero length, %0d table full.",
                 n_sent, n_by_status[ST_OK], n_by_status[ST_NOFIT],
                 n_by_status[ST_ZERO], n_by_status[ST_FULL]);
        $display("The free list held at most %0d extents.", peak_entries);
        if (n_fail == 0) begin
            $display("PASS extent_free_list_allocator");
        end else begin
            $display("FAIL extent_free_list_allocator");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAIL extent_free_list_allocator");
        $finish;
    end

endmodule
